@@ hdl/gvfc_pkg.sv @@
// gvfc_pkg: shared constants and types for the grid void fillability check
// no dependencies
`default_nettype none
package gvfc_pkg;
    localparam int GRID_CELLS = 1024;
    localparam int IDX_W      = $clog2(GRID_CELLS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int OFS_W      = 11;

    localparam logic [1:0] CODE_EMPTY    = 2'd0;
    localparam logic [1:0] CODE_BORDER   = 2'd1;

    localparam logic [1:0] REG_EAST  = 2'd0;
    localparam logic [1:0] REG_NORTH = 2'd1;
    localparam logic [1:0] REG_WEST  = 2'd2;
    localparam logic [1:0] REG_SOUTH = 2'd3;

    localparam logic KIND_WRITE = 1'b0;

    // grid entry: cell code plus probe mark, kept in one word
    typedef struct packed {
        logic       mark;
        logic [1:0] code;
    } grid_word_t;

    // memory port request
    typedef struct packed {
        logic             rd;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        grid_word_t       wdata;
    } grid_req_t;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic signed [OFS_W-1:0] ofs);
        logic signed [OFS_W+IDX_W:0] s;
        s = $signed({1'b0, base}) + ofs;
        return s[IDX_W-1:0];
    endfunction
endpackage
`default_nettype wire

@@ hdl/gvfc_grid_mem.sv @@
// gvfc_grid_mem: grid store with probe marks, one read and one write port
// depends on gvfc_pkg
`default_nettype none
module gvfc_grid_mem (
    input  wire                    aclk,
    input  wire gvfc_pkg::grid_req_t req,
    output gvfc_pkg::grid_word_t   rdata
);
    import gvfc_pkg::*;
    grid_word_t mem [GRID_CELLS];
    always_ff @(posedge aclk) begin
        if (req.we) mem[req.waddr] <= req.wdata;
        if (req.rd) rdata <= mem[req.raddr];
    end
endmodule
`default_nettype wire

@@ hdl/gvfc_queue_mem.sv @@
// gvfc_queue_mem: visit queue storage, one write and one read port
// depends on gvfc_pkg
`default_nettype none
module gvfc_queue_mem (
    input  wire                           aclk,
    input  wire                           we,
    input  wire [gvfc_pkg::IDX_W-1:0]     waddr,
    input  wire [gvfc_pkg::IDX_W-1:0]     wdata,
    input  wire                           rd,
    input  wire [gvfc_pkg::IDX_W-1:0]     raddr,
    output logic [gvfc_pkg::IDX_W-1:0]    rdata
);
    import gvfc_pkg::*;
    logic [IDX_W-1:0] mem [GRID_CELLS];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (rd) rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hdl/grid_void_fillability_check.sv @@
// grid_void_fillability_check: top level, flood-fill sequencer over grid and queue memories
// depends on gvfc_pkg, gvfc_grid_mem, gvfc_queue_mem
// evaluate item: per region cell one queue read and four grid read-modify-writes, then a clear
// pass that reads each queued cell back and writes its mark clear
// throughput: one item at a time, set by the single grid memory port pair
// reset: synchronous active-low, clears control and counters, loads default offsets; memories are not cleared
`default_nettype none
module grid_void_fillability_check (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // tdata: cell_index[9:0], cell_code[11:10], query_site[21:12],
    // seed_cell[31:22], sites_left[42:32], zero fill [47:43]
    input  wire  [47:0] s_tdata,
    // tuser: kind
    input  wire  [0:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // tdata: fillable[0], zero fill [7:1]
    output logic [7:0]  m_tdata,
    // tuser: is_evaluation
    output logic [0:0]  m_tuser,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [10:0] cfg_data
);
    import gvfc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SEED, S_POP, S_POPW, S_NRD, S_NCHK, S_TALLY, S_CLR_RD, S_CLR_WR,
        S_DONE, S_OUT
    } state_t;

    state_t state_reg;
    logic signed [OFS_W-1:0] ofs_reg [4];
    logic [IDX_W-1:0] query_reg, seed_reg, v_reg, w_reg;
    logic [CNT_W-1:0] left_reg, head_reg, tail_reg;
    logic [CNT_W-1:0] cnt_reg [2];
    logic [CNT_W-1:0] dead_reg [2];
    logic [2:0] deg_reg;
    logic [1:0] dir_reg;
    logic border_reg, fill_reg, eval_reg;

    grid_req_t  greq;
    grid_word_t grd;
    logic q_we, q_rd;
    logic [IDX_W-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

    gvfc_grid_mem u_grid (.aclk(aclk), .req(greq), .rdata(grd));
    gvfc_queue_mem u_queue (.aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
                            .rd(q_rd), .raddr(q_raddr), .rdata(q_rdata));

    assign s_tready  = (state_reg == S_IDLE) && !m_tvalid;
    // offsets only change while no item is in flight
    assign cfg_ready = (state_reg == S_IDLE) && !m_tvalid;
    assign m_tdata   = {7'd0, fill_reg};
    assign m_tuser   = eval_reg;

    // parity test pieces, valid in S_DONE
    logic pf, pl;
    logic [CNT_W-1:0] need_pf, need_npf, area;
    logic [CNT_W:0] left_p1;
    assign pf       = ~query_reg[0];
    assign pl       = query_reg[0] ^ left_reg[0];
    assign left_p1  = {1'b0, left_reg} + 1'b1;
    assign need_pf  = left_p1[CNT_W:1];
    assign need_npf = {1'b0, left_reg[CNT_W-1:1]};
    assign area     = cnt_reg[0] + cnt_reg[1];

    // memory request decode
    always_comb begin
        greq = '0;
        q_we = 1'b0; q_waddr = tail_reg[IDX_W-1:0]; q_wdata = w_reg;
        q_rd = 1'b0; q_raddr = head_reg[IDX_W-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (s_tuser[0] == KIND_WRITE) begin
                        greq.we = 1'b1;
                        greq.waddr = s_tdata[9:0];
                        greq.wdata = '{mark: 1'b0, code: s_tdata[11:10]};
                    end else begin
                        greq.rd = 1'b1;
                        greq.raddr = s_tdata[31:22];
                    end
                end
            end
            S_SEED: begin
                if (grd.code == CODE_EMPTY && !grd.mark) begin
                    greq.we = 1'b1; greq.waddr = seed_reg;
                    greq.wdata = '{mark: 1'b1, code: CODE_EMPTY};
                    q_we = 1'b1; q_waddr = '0; q_wdata = seed_reg;
                end
            end
            S_POP: q_rd = 1'b1;
            S_NRD: begin
                greq.rd = 1'b1; greq.raddr = w_reg;
            end
            S_NCHK: begin
                if (!grd.mark && grd.code == CODE_EMPTY) begin
                    greq.we = 1'b1; greq.waddr = w_reg;
                    greq.wdata = '{mark: 1'b1, code: CODE_EMPTY};
                    q_we = (tail_reg < CNT_W'(GRID_CELLS));
                end
            end
            S_CLR_RD: q_rd = 1'b1;
            S_CLR_WR: begin
                greq.we = 1'b1; greq.waddr = q_rdata;
                greq.wdata = '{mark: 1'b0, code: CODE_EMPTY};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_tvalid <= 1'b0;
            fill_reg <= 1'b0;
            eval_reg <= 1'b0;
            ofs_reg[0] <= 11'sd1;
            ofs_reg[1] <= -11'sd33;
            ofs_reg[2] <= -11'sd1;
            ofs_reg[3] <= 11'sd33;
            cnt_reg[0] <= '0; cnt_reg[1] <= '0;
            dead_reg[0] <= '0; dead_reg[1] <= '0;
            border_reg <= 1'b0;
            head_reg <= '0; tail_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_EAST:  ofs_reg[0] <= cfg_data;
                    REG_NORTH: ofs_reg[1] <= cfg_data;
                    REG_WEST:  ofs_reg[2] <= cfg_data;
                    REG_SOUTH: ofs_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        query_reg <= s_tdata[21:12];
                        seed_reg  <= s_tdata[31:22];
                        left_reg  <= s_tdata[42:32];
                        if (s_tuser[0] == KIND_WRITE) begin
                            fill_reg <= 1'b0; eval_reg <= 1'b0;
                            state_reg <= S_OUT;
                        end else begin
                            cnt_reg[0] <= '0; cnt_reg[1] <= '0;
                            dead_reg[0] <= '0; dead_reg[1] <= '0;
                            border_reg <= 1'b0;
                            head_reg <= '0; tail_reg <= '0;
                            eval_reg <= 1'b1;
                            state_reg <= S_SEED;
                        end
                    end
                end
                S_SEED: begin
                    if (grd.code == CODE_EMPTY && !grd.mark) begin
                        tail_reg <= CNT_W'(1);
                        state_reg <= S_POP;
                    end else begin
                        fill_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_POP: begin
                    head_reg <= head_reg + 1'b1;
                    state_reg <= S_POPW;
                end
                S_POPW: begin
                    v_reg <= q_rdata;
                    w_reg <= wrap_add(q_rdata, ofs_reg[0]);
                    dir_reg <= '0; deg_reg <= '0;
                    state_reg <= S_NRD;
                end
                S_NRD: state_reg <= S_NCHK;
                S_NCHK: begin
                    // one neighbour per pass; write-back lands before the next read
                    if (grd.mark) deg_reg <= deg_reg + 1'b1;
                    else if (grd.code == CODE_BORDER) border_reg <= 1'b1;
                    else if (grd.code == CODE_EMPTY) begin
                        deg_reg <= deg_reg + 1'b1;
                        if (tail_reg < CNT_W'(GRID_CELLS)) tail_reg <= tail_reg + 1'b1;
                    end else if (w_reg == query_reg) deg_reg <= deg_reg + 1'b1;
                    dir_reg <= dir_reg + 1'b1;
                    w_reg <= wrap_add(v_reg, ofs_reg[2'(dir_reg + 1'b1)]);
                    state_reg <= (dir_reg == 2'd3) ? S_TALLY : S_NRD;
                end
                S_TALLY: begin
                    cnt_reg[v_reg[0]] <= cnt_reg[v_reg[0]] + 1'b1;
                    if (deg_reg == 3'd1) dead_reg[v_reg[0]] <= dead_reg[v_reg[0]] + 1'b1;
                    if (head_reg < tail_reg) state_reg <= S_POP;
                    else begin
                        head_reg <= '0;
                        state_reg <= S_CLR_RD;
                    end
                end
                S_CLR_RD: begin
                    head_reg <= head_reg + 1'b1;
                    state_reg <= S_CLR_WR;
                end
                S_CLR_WR: state_reg <= (head_reg < tail_reg) ? S_CLR_RD : S_DONE;
                S_DONE: begin
                    fill_reg <= !border_reg && (area <= left_reg)
                        && (dead_reg[pl] <= CNT_W'(1)) && (dead_reg[~pl] == '0)
                        && (cnt_reg[pf] == need_pf) && (cnt_reg[~pf] == need_npf);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    m_tvalid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // the queue never reads past what was pushed
    a_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP) |-> (head_reg < tail_reg))
        else $error("queue underrun");
    // a result only appears after the sequencer returns to idle
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (state_reg == S_IDLE))
        else $error("result outside idle");
    // no item taken while a result waits
    a_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("accept with pending result");
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for grid_void_fillability_check
// depends on gvfc_pkg and the grid_void_fillability_check rtl; an in-bench flood-fill predictor
// checks every result item
`default_nettype none
module tb_top;
    import gvfc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // one input item: kind plus every tdata field
    typedef struct {
        logic        kind;
        logic [9:0]  cell_index;
        logic [1:0]  cell_code;
        logic [9:0]  query_site;
        logic [9:0]  seed_cell;
        logic [10:0] sites_left;
    } grid_item_t;

    // directed row: item plus an optional hand-written answer
    typedef struct {
        grid_item_t item;
        logic       typed;
        logic       typed_fill;
    } grid_row_t;

    // one expected result item
    typedef struct {
        logic fillable;
        logic is_evaluation;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [7:0]  m_tdata;
    wire  [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    grid_void_fillability_check dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // shadow copy of the grid and the offset registers
    logic [1:0] grid_shadow [GRID_CELLS];
    int         nbr_offset [4];
    verdict_t   pending_verdicts [$];

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int eval_count = 0;
    int fillable_count = 0;
    int write_count = 0;

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_val, got_val, $realtime);
        error_count++;
    endtask

    // flood the empty region from the seed and apply the fillability tests
    function automatic logic flood_fillable(input int query, input int seed, input int left,
                                            output int area);
        bit mark [GRID_CELLS];
        int region [$];
        int cnt [2];
        int dead [2];
        int need [2];
        int head, v, w, deg, pf, pl;
        bit border;
        cnt = '{0, 0};
        dead = '{0, 0};
        border = 0;
        area = 0;
        pf = (query + 1) & 1;
        pl = (query + left) & 1;
        need[pf] = (left + 1) / 2;
        need[1 - pf] = left / 2;
        if (grid_shadow[seed] != CODE_EMPTY) return 1'b0;
        region.push_back(seed);
        mark[seed] = 1;
        head = 0;
        while (head < region.size()) begin
            v = region[head];
            head++;
            deg = 0;
            for (int d = 0; d < 4; d++) begin
                w = (v + nbr_offset[d] + 2 * GRID_CELLS) % GRID_CELLS;
                if (mark[w]) begin
                    deg++;
                end else if (grid_shadow[w] == CODE_BORDER) begin
                    border = 1;
                end else if (grid_shadow[w] == CODE_EMPTY) begin
                    mark[w] = 1;
                    region.push_back(w);
                    deg++;
                end else if (w == query) begin
                    deg++;
                end
            end
            cnt[v & 1]++;
            if (deg == 1) dead[v & 1]++;
        end
        area = region.size();
        if (border) return 1'b0;
        if (area > left) return 1'b0;
        if (dead[pl] > 1 || dead[1 - pl] != 0) return 1'b0;
        return (cnt[0] == need[0] && cnt[1] == need[1]);
    endfunction

    // predict the item, queue its verdict, then hand it to the block
    task automatic send_item(input grid_item_t it, input logic typed, input logic typed_fill);
        verdict_t vd;
        int area;
        vd.is_evaluation = it.kind;
        if (it.kind == KIND_WRITE) begin
            grid_shadow[it.cell_index] = it.cell_code;
            vd.fillable = 1'b0;
            write_count++;
        end else begin
            vd.fillable = flood_fillable(it.query_site, it.seed_cell, it.sites_left, area);
            eval_count++;
            fillable_count += vd.fillable;
        end
        // hand-typed answers must agree with the predictor
        if (typed && vd.fillable !== typed_fill)
            report_mismatch("directed answer vs predictor", typed_fill, vd.fillable);
        if (typed) vd.fillable = typed_fill;
        pending_verdicts.push_back(vd);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {5'b0, it.sites_left, it.seed_cell, it.query_site, it.cell_code,
                     it.cell_index};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold the sender off until every queued verdict has come back
    task automatic drain_results;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_offsets(input int east, input int north, input int west,
                                 input int south);
        int vals [4];
        logic [1:0] regs [4];
        vals = '{east, north, west, south};
        regs = '{REG_EAST, REG_NORTH, REG_WEST, REG_SOUTH};
        drain_results();
        for (int r = 0; r < 4; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[r];
            cfg_data  <= vals[r][10:0];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            nbr_offset[r] = vals[r];
            cfg_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    function automatic grid_item_t rand_write;
        grid_item_t it;
        it.kind = KIND_WRITE;
        it.cell_index = 10'($urandom);
        it.cell_code = 2'($urandom);
        it.query_site = 10'($urandom);
        it.seed_cell = 10'($urandom);
        it.sites_left = 11'($urandom);
        return it;
    endfunction

    // evaluation aimed at real regions with sites_left near the area
    function automatic grid_item_t rand_eval;
        grid_item_t it;
        int area, start, pick;
        logic dummy;
        it = rand_write();
        it.kind = ~KIND_WRITE;
        it.seed_cell = 10'($urandom);
        if ($urandom_range(99) < 75) begin
            start = $urandom_range(GRID_CELLS - 1);
            for (int k = 0; k < GRID_CELLS; k++) begin
                if (grid_shadow[(start + k) % GRID_CELLS] == CODE_EMPTY) begin
                    it.seed_cell = 10'((start + k) % GRID_CELLS);
                    break;
                end
            end
        end
        if ($urandom_range(1))
            it.query_site = 10'((it.seed_cell + nbr_offset[$urandom_range(3)]
                                 + 2 * GRID_CELLS) % GRID_CELLS);
        dummy = flood_fillable(it.query_site, it.seed_cell, 0, area);
        pick = $urandom_range(99);
        if (pick < 60)
            it.sites_left = 11'((area + int'($urandom_range(2)) - 1 < 0) ? 0 :
                                area + int'($urandom_range(2)) - 1);
        else if (pick < 70)
            it.sites_left = 11'd1024;
        else
            it.sites_left = 11'($urandom_range(1024));
        return it;
    endfunction

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 35) send_item(rand_write(), 1'b0, 1'b0);
            else send_item(rand_eval(), 1'b0, 1'b0);
        end
    endtask

    // result side: random stall and compare against the oldest verdict
    always @(posedge aclk) begin
        verdict_t vd;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result item with nothing pending", 0, 1);
            end else begin
                vd = pending_verdicts.pop_front();
                if (m_tdata[0] !== vd.fillable)
                    report_mismatch("fillable", vd.fillable, m_tdata[0]);
                if (m_tuser[0] !== vd.is_evaluation)
                    report_mismatch("is_evaluation", vd.is_evaluation, m_tuser[0]);
            end
        end
    end

    grid_row_t directed_rows [$];

    function automatic grid_row_t row(input logic kind, input int idx, input int code,
                                      input int q, input int s, input int left,
                                      input logic typed, input logic fill);
        grid_row_t r;
        r.item = '{kind, idx[9:0], code[1:0], q[9:0], s[9:0], left[10:0]};
        r.typed = typed;
        r.typed_fill = fill;
        return r;
    endfunction

    initial begin
        int code;
        grid_item_t it;
        nbr_offset = '{1, -33, -1, 33};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // load every cell first so no evaluation reads an unwritten cell;
        // mostly occupied so regions stay small
        for (int c = 0; c < GRID_CELLS; c++) begin
            code = $urandom_range(99);
            it = rand_write();
            it.cell_index = 10'(c);
            it.cell_code = (code < 25) ? CODE_EMPTY : (code < 35) ? CODE_BORDER :
                           (code < 95) ? 2'd2 : 2'd3;
            send_item(it, 1'b0, 1'b0);
        end

        // directed part under reset offsets
        directed_rows.push_back(row(KIND_WRITE, 0, 2, 0, 0, 0, 1, 0));
        // seed occupied, sites_left equal to the grid size
        directed_rows.push_back(row(~KIND_WRITE, 0, 0, 0, 0, 1024, 1, 0));
        directed_rows.push_back(row(KIND_WRITE, 1023, 1, 0, 0, 0, 1, 0));
        // seed on a border cell, zero sites left
        directed_rows.push_back(row(~KIND_WRITE, 0, 0, 1023, 1023, 0, 1, 0));
        // code three behaves as occupied
        directed_rows.push_back(row(KIND_WRITE, 5, 3, 0, 0, 0, 1, 0));
        directed_rows.push_back(row(~KIND_WRITE, 0, 0, 6, 5, 1, 1, 0));
        // single empty cell walled in, query site next to it
        directed_rows.push_back(row(KIND_WRITE, 200, 0, 0, 0, 0, 1, 0));
        directed_rows.push_back(row(KIND_WRITE, 201, 2, 0, 0, 0, 1, 0));
        directed_rows.push_back(row(KIND_WRITE, 199, 2, 0, 0, 0, 1, 0));
        directed_rows.push_back(row(KIND_WRITE, 167, 2, 0, 0, 0, 1, 0));
        directed_rows.push_back(row(KIND_WRITE, 233, 2, 0, 0, 0, 1, 0));
        directed_rows.push_back(row(~KIND_WRITE, 0, 0, 201, 200, 1, 1, 1));
        // area above sites_left, then parity split off
        directed_rows.push_back(row(~KIND_WRITE, 0, 0, 201, 200, 0, 1, 0));
        directed_rows.push_back(row(~KIND_WRITE, 0, 0, 201, 200, 2, 1, 0));
        // border neighbour spoils the region
        directed_rows.push_back(row(KIND_WRITE, 167, 1, 0, 0, 0, 1, 0));
        directed_rows.push_back(row(~KIND_WRITE, 0, 0, 201, 200, 1, 1, 0));
        // empty query site joins the region
        directed_rows.push_back(row(KIND_WRITE, 167, 2, 0, 0, 0, 1, 0));
        directed_rows.push_back(row(KIND_WRITE, 201, 0, 0, 0, 0, 1, 0));
        directed_rows.push_back(row(~KIND_WRITE, 0, 0, 201, 200, 2, 0, 0));
        // neighbours wrapping past both ends of the grid
        directed_rows.push_back(row(KIND_WRITE, 0, 0, 0, 0, 0, 1, 0));
        directed_rows.push_back(row(~KIND_WRITE, 1023, 3, 1, 0, 1023, 0, 0));
        directed_rows.push_back(row(~KIND_WRITE, 0, 0, 1023, 0, 1, 0, 0));

        send_idle_pct = 25;
        recv_idle_pct = 75;
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed,
                      directed_rows[i].typed_fill);
        random_phase(25);

        // offsets of magnitude 1023, zero offset and repeated offsets
        write_offsets(-1023, 1023, 0, 1023);
        random_phase(15);

        send_idle_pct = 75;
        recv_idle_pct = 25;
        write_offsets(1023, -1023, -1023, 0);
        random_phase(15);
        drain_results();
        random_phase(10);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_offsets(1, -32, -1, 32);
        random_phase(20);
        write_offsets(1, -33, -1, 33);
        random_phase(15);

        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d cell writes and %0d evaluations (%0d fillable)",
                 write_count, eval_count, fillable_count);
        $display("over five offset settings and three stall patterns");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", pending_verdicts.size());
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

@@ grid_void_fillability_check.f @@
hdl/gvfc_pkg.sv
hdl/gvfc_grid_mem.sv
hdl/gvfc_queue_mem.sv
hdl/grid_void_fillability_check.sv
tb/tb_top.sv
